// ===== sv/rsdf_pkg.sv =====
// Shared types and constants for the recent sender duplicate filter.
package rsdf_pkg;

   localparam int LOG_DEPTH_DEFAULT = 16;

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int KIND_W    = 2;
   localparam int TIME_W    = 32;
   localparam int WINDOW_W  = 31;
   localparam int SLOT_W    = 4;
   localparam int KEY_W     = ADDR_W + PORT_W;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(20000);

   // Invalidation keeps address bytes two to four and drops first byte and port.
   localparam logic [KEY_W-1:0] INVALIDATE_MASK = 48'h00FF_FFFF_0000;

   typedef struct packed {
      logic [KEY_W-1:0]  addr_port;
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Head compare results handed to the sequencer.
   typedef struct packed {
      logic hit;
      logic age_ok;
   } status_type;

   // Sequencer commands to the ring and the result register.
   typedef struct packed {
      logic shift;
      logic kill;
      logic finish;
      logic load;
   } ctrl_type;

endpackage

// ===== sv/rsdf_cell.sv =====
// One log entry of the ring: loads a new entry or takes its neighbor's.
module rsdf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  logic                shift_en,
   input  rsdf_pkg::entry_type load_data,
   input  rsdf_pkg::entry_type shift_data,
   output rsdf_pkg::entry_type entry
);
   import rsdf_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (load_en) begin
         entry_ff <= load_data;
      end else if (shift_en) begin
         entry_ff <= shift_data;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== sv/rsdf_ctrl.sv =====
// Sequencer: walk step count, fresh-match flag, ring pointer and handshake control.
module rsdf_ctrl #(
   parameter int LOG_DEPTH = rsdf_pkg::LOG_DEPTH_DEFAULT,
   localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_busy,
   input  rsdf_pkg::status_type status,
   output rsdf_pkg::ctrl_type   ctrl,
   output logic                 found,
   output logic [PTR_W-1:0]     pointer,
   output logic                 busy
);
   import rsdf_pkg::*;

   localparam logic [PTR_W-1:0] LAST = PTR_W'(LOG_DEPTH - 1);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] step_ff, step_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             found_ff, found_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_WALK;
         ST_WALK:   if (step_ff == LAST) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_WALK: begin
            ctrl.shift = 1'b1;
            ctrl.kill  = !found_ff && status.hit && !status.age_ok;
         end
         ST_FINISH: begin
            ctrl.finish = !rsp_busy;
            ctrl.load   = !rsp_busy && !found_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Step count, fresh flag and pointer.
   always_comb begin
      step_in  = step_ff;
      found_in = found_ff;
      ptr_in   = ptr_ff;
      if (req_fire) begin
         step_in  = '0;
         found_in = 1'b0;
      end else if (ctrl.shift) begin
         step_in = step_ff + PTR_W'(1);
         if (status.hit && status.age_ok) found_in = 1'b1;
      end
      if (ctrl.load) begin
         ptr_in = (ptr_ff == LAST) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         found_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         found_ff <= found_in;
         ptr_ff   <= ptr_in;
      end
   end

   assign found   = found_ff;
   assign pointer = ptr_ff;

endmodule

// ===== sv/recent_sender_duplicate_filter.sv =====
// Top level of the recent sender duplicate filter: ring of log cells and result register.
//
// Each accepted transfer (sender address, port, request kind, current time)
// is checked against a log of LOG_DEPTH entries held in a ring of cells. The
// ring rotates one cell per cycle past a single compare at the head, so slots
// are visited in order 0 to LOG_DEPTH-1. A match on address, port and kind
// whose age (now minus stored time, mod 2^32, taken as signed) lies from 0 to
// window_ms is a duplicate; later slots are then left untouched. An older or
// future-dated match has its port and first address byte cleared as it passes
// the head. After a full turn every entry is back in its home cell; if no
// fresh match was seen, the transfer is logged at the ring pointer, which then
// advances and wraps. The result gives is_new and the slot written (or the
// current pointer for a duplicate), low four bits. Each item passes through
// the walk and finish steps before the next is accepted; req_stall stays
// high meanwhile. A finished result waits in the output register while
// rsp_stall is high, and the block then holds the finish step until the
// register frees. window_ms resets to 20000 and is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. All log entries reset to zero, with
// no valid bits: an empty slot can match an all-zero address, port and kind.
module recent_sender_duplicate_filter #(
   parameter int LOG_DEPTH = rsdf_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rsdf_pkg::WINDOW_W-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rsdf_pkg::ADDR_W-1:0]   req_sender_addr,
   input  logic [rsdf_pkg::PORT_W-1:0]   req_sender_port,
   input  logic [rsdf_pkg::KIND_W-1:0]   req_message_kind,
   input  logic [rsdf_pkg::TIME_W-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_new,
   output logic [rsdf_pkg::SLOT_W-1:0]   rsp_slot_written
);
   import rsdf_pkg::*;

   localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   logic [WINDOW_W-1:0] window_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [TIME_W-1:0]   now_ff;

   logic                rsp_valid_ff;
   logic                rsp_is_new_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   entry_type           entries [LOG_DEPTH];
   entry_type           head_back;
   entry_type           new_entry;
   logic [TIME_W-1:0]   age;
   status_type          status;
   ctrl_type            ctrl;
   logic                found;
   logic [PTR_W-1:0]    pointer;
   logic                busy;
   logic                req_fire;
   logic                rsp_busy;

   assign req_fire  = req_valid && !busy;
   assign req_stall = busy;
   assign rsp_busy  = rsp_valid_ff && rsp_stall;

   // Window register.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Hold the message for the whole walk.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff  <= {req_sender_addr, req_sender_port};
         kind_ff <= req_message_kind;
         now_ff  <= req_now_ms;
      end
   end

   // Compare at the head of the ring.
   assign age           = now_ff - entries[0].stamp;
   assign status.hit    = (entries[0].addr_port == key_ff) && (entries[0].kind == kind_ff);
   assign status.age_ok = (age <= {1'b0, window_ff});

   // Head entry returns to the tail, invalidated on a stale match.
   always_comb begin
      head_back = entries[0];
      if (ctrl.kill) head_back.addr_port = entries[0].addr_port & INVALIDATE_MASK;
   end

   assign new_entry.addr_port = key_ff;
   assign new_entry.kind      = kind_ff;
   assign new_entry.stamp     = now_ff;

   rsdf_ctrl #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_busy (rsp_busy),
      .status   (status),
      .ctrl     (ctrl),
      .found    (found),
      .pointer  (pointer),
      .busy     (busy)
   );

   for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
      entry_type shift_data;
      if (i == LOG_DEPTH - 1) begin : g_tail
         assign shift_data = head_back;
      end else begin : g_body
         assign shift_data = entries[i+1];
      end

      rsdf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load_en    (ctrl.load && (pointer == PTR_W'(i))),
         .shift_en   (ctrl.shift),
         .load_data  (new_entry),
         .shift_data (shift_data),
         .entry      (entries[i])
      );
   end

   // Result register: load at finish, drop once the transfer is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_is_new_ff <= !found;
         rsp_slot_ff   <= SLOT_W'(pointer);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_new       = rsp_is_new_ff;
   assign rsp_slot_written = rsp_slot_ff;

endmodule

// ===== sv/rsdf_checker.sv =====
// Port-level checks for the recent sender duplicate filter, bound to the top level.
module rsdf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_is_new,
   input logic [rsdf_pkg::SLOT_W-1:0]   rsp_slot_written
);
   import rsdf_pkg::*;

   // Reset leaves the block empty and ready.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // One item at a time: an accepted transfer closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after a transfer");

   // A result is only produced while an item is in work.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_is_new) && $stable(rsp_slot_written)))
      else $error("stalled result changed");

endmodule

bind recent_sender_duplicate_filter rsdf_checker u_rsdf_checker (.*);
